>>> hdl/sbm_pkg.sv
// Stereo SAD block matcher package: payload types, register indexes and limits.
// No dependencies.
package sbm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_BLOCK_DEF  = 11;
  localparam int MAX_DISP_DEF   = 64;
  localparam int MAX_HEIGHT     = 1024;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISPARITY = 2'd3;

  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT  = 11'd480;
  localparam logic [3:0]  RST_BLOCK_SIZE    = 4'd5;
  localparam logic [6:0]  RST_MAX_DISPARITY = 7'd64;

  typedef struct packed {
    logic [7:0] left_pixel;
    logic [7:0] right_pixel;
  } in_t;

  typedef struct packed {
    logic [5:0] best_disparity;
    logic [9:0] pixel_column;
    logic [9:0] pixel_row;
    logic       frame_last;
  } out_t;

endpackage

>>> hdl/sbm_line_store.sv
// Left and right line stores of the stereo SAD block matcher.
// One write port and one registered read port each; uses no package.
module sbm_line_store #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 11,
  localparam int SW  = $clog2(MAX_BLOCK),
  localparam int CIW = $clog2(MAX_WIDTH)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [SW-1:0]  wslot_i,
  input  logic [CIW-1:0] wcol_i,
  input  logic [7:0]     wleft_i,
  input  logic [7:0]     wright_i,
  input  logic [SW-1:0]  rslot_i,
  input  logic [CIW-1:0] rcol_left_i,
  input  logic [CIW-1:0] rcol_right_i,
  output logic [7:0]     rleft_o,
  output logic [7:0]     rright_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_BLOCK;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0] left_mem  [DEPTH];
  logic [7:0] right_mem [DEPTH];
  logic [AW-1:0] waddr, raddr_l, raddr_r, rrow;

  assign waddr   = AW'(AW'(wslot_i) * AW'(MAX_WIDTH)) + AW'(wcol_i);
  assign rrow    = AW'(AW'(rslot_i) * AW'(MAX_WIDTH));
  assign raddr_l = rrow + AW'(rcol_left_i);
  assign raddr_r = rrow + AW'(rcol_right_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      left_mem[waddr]  <= wleft_i;
      right_mem[waddr] <= wright_i;
    end
    rleft_o  <= left_mem[raddr_l];
    rright_o <= right_mem[raddr_r];
  end

endmodule

>>> hdl/stereo_sad_block_matcher.sv
// Stereo block matcher, sum of absolute differences, winner take all.
// Uses sbm_pkg and sbm_line_store.
//
// Each transfer writes one left/right pixel pair into the line stores. A pair
// that completes the window of an interior pixel starts a search: the window
// is read from the stores one sample pair per cycle, once for each of D
// disparities, D being the number of valid disparities
// (min(max_disparity, x-hw+1)); when max_disparity is zero no window is read.
// Other transfers start no search. The single read port of each line store
// sets this pace. Input stall is high from the start of the search until its
// result enters the output register; a finished result waits there without
// blocking the next transfer. Stores need no clearing after reset.
module stereo_sad_block_matcher #(
  parameter int MAX_WIDTH = sbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = sbm_pkg::MAX_BLOCK_DEF,
  parameter int MAX_DISP  = sbm_pkg::MAX_DISP_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sbm_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sbm_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sbm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int SW   = $clog2(MAX_BLOCK);
  localparam int LW   = SW + 1;
  localparam int CIW  = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int EW   = (WW > 11) ? WW : 11;
  localparam int DW   = $clog2(MAX_DISP + 1);
  localparam int SUMW = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [10:0] cfg_width_q, cfg_height_q;
  logic [3:0]  cfg_block_q;
  logic [6:0]  cfg_disp_q;

  logic [1:0]     state_q, state_d;
  logic [CIW-1:0] col_q, col_d;
  logic [9:0]     row_q, row_d;
  logic [SW-1:0]  slot_q, slot_d;

  logic [CIW-1:0] x_q, x_d, col0_q, col0_d, lcol_q, lcol_d;
  logic [9:0]     y_q, y_d;
  logic [2:0]     hw_q, hw_d;
  logic [SW-1:0]  base_q, base_d, ws_q, ws_d;
  logic [DW-1:0]  dend_q, dend_d, d_q, d_d;
  logic           last_q, last_d;
  logic [3:0]     wx_q, wx_d, wy_q, wy_d;

  logic           rv_q, rv_d, rl_q, rl_d;
  logic [DW-1:0]  rdd_q, rdd_d;
  logic [SUMW-1:0] acc_q, acc_d, best_q, best_d;
  logic [DW-1:0]  bestd_q, bestd_d;
  logic           found_q, found_d;

  logic           out_valid_q, out_valid_d;
  sbm_pkg::out_t  out_q, out_d;

  logic [EW-1:0]  w_eff;
  logic [10:0]    h_eff;
  logic [2:0]     hw_eff;
  logic [3:0]     twohw;
  logic [DW-1:0]  nd_eff;
  logic [CIW-1:0] c_cur, xm;
  logic [9:0]     r_cur;
  logic [SW-1:0]  slot_cur;
  logic           interior, in_acc, out_free;
  logic [7:0]     ldat, rdat, diff;
  logic [SUMW-1:0] sad;
  logic [CIW-1:0] rcol;
  logic [LW-1:0]  base_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= sbm_pkg::RST_IMAGE_WIDTH;
      cfg_height_q <= sbm_pkg::RST_IMAGE_HEIGHT;
      cfg_block_q  <= sbm_pkg::RST_BLOCK_SIZE;
      cfg_disp_q   <= sbm_pkg::RST_MAX_DISPARITY;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sbm_pkg::REG_IMAGE_WIDTH:   cfg_width_q  <= cfg_data_i;
        sbm_pkg::REG_IMAGE_HEIGHT:  cfg_height_q <= cfg_data_i;
        sbm_pkg::REG_BLOCK_SIZE:    cfg_block_q  <= cfg_data_i[3:0];
        sbm_pkg::REG_MAX_DISPARITY: cfg_disp_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_q == 11'd0) begin
      w_eff = EW'(1);
    end else if (EW'(cfg_width_q) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(cfg_width_q);
    end
    if (cfg_height_q == 11'd0) begin
      h_eff = 11'd1;
    end else if (cfg_height_q > 11'(sbm_pkg::MAX_HEIGHT)) begin
      h_eff = 11'(sbm_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg_height_q;
    end
    if ({cfg_block_q[3:1], 1'b1} > 4'(MAX_BLOCK)) begin
      hw_eff = 3'((MAX_BLOCK - 1) / 2);
    end else begin
      hw_eff = cfg_block_q[3:1];
    end
    twohw = {hw_eff, 1'b0};
    if (9'(cfg_disp_q) > 9'(MAX_DISP)) begin
      nd_eff = DW'(MAX_DISP);
    end else begin
      nd_eff = DW'(cfg_disp_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    c_cur    = (EW'(col_q) >= w_eff) ? '0 : col_q;
    r_cur    = (11'(row_q) >= h_eff) ? '0 : row_q;
    slot_cur = (11'(row_q) >= h_eff) ? '0 : slot_q;
    interior = (10'(twohw) <= r_cur) && (CIW'(twohw) <= c_cur);
    xm       = c_cur - CIW'(twohw);
    base_ext = (LW'(slot_cur) >= LW'(twohw)) ? (LW'(slot_cur) - LW'(twohw))
             : (LW'(slot_cur) + LW'(MAX_BLOCK) - LW'(twohw));
  end

  sbm_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_store (
    .clk_i        (clk_i),
    .we_i         (in_acc),
    .wslot_i      (slot_cur),
    .wcol_i       (c_cur),
    .wleft_i      (in_data_i.left_pixel),
    .wright_i     (in_data_i.right_pixel),
    .rslot_i      (ws_q),
    .rcol_left_i  (lcol_q),
    .rcol_right_i (rcol),
    .rleft_o      (ldat),
    .rright_o     (rdat)
  );

  assign rcol = lcol_q - CIW'(d_q);
  assign diff = (ldat > rdat) ? (ldat - rdat) : (rdat - ldat);
  assign sad  = acc_q + SUMW'(diff);

  always_comb begin
    state_d = state_q;
    col_d = col_q; row_d = row_q; slot_d = slot_q;
    x_d = x_q; y_d = y_q; hw_d = hw_q; base_d = base_q; dend_d = dend_q;
    col0_d = col0_q; last_d = last_q;
    d_d = d_q; wx_d = wx_q; wy_d = wy_q; ws_d = ws_q; lcol_d = lcol_q;
    rv_d = 1'b0; rl_d = 1'b0; rdd_d = d_q;
    acc_d = acc_q; best_d = best_q; bestd_d = bestd_q; found_d = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;

    if (rv_q) begin
      if (rl_q) begin
        acc_d = '0;
        if (!found_q || sad < best_q) begin
          found_d = 1'b1;
          best_d  = sad;
          bestd_d = rdd_q;
        end
      end else begin
        acc_d = sad;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (EW'(c_cur) + EW'(1) >= w_eff) begin
            col_d = '0;
            if (11'(r_cur) + 11'd1 >= h_eff) begin
              row_d  = '0;
              slot_d = '0;
            end else begin
              row_d  = r_cur + 10'd1;
              slot_d = (slot_cur == SW'(MAX_BLOCK - 1)) ? '0 : slot_cur + SW'(1);
            end
          end else begin
            col_d  = c_cur + CIW'(1);
            row_d  = r_cur;
            slot_d = slot_cur;
          end
          if (interior) begin
            x_d     = c_cur - CIW'(hw_eff);
            y_d     = r_cur - 10'(hw_eff);
            hw_d    = hw_eff;
            col0_d  = xm;
            base_d  = SW'(base_ext);
            last_d  = (11'(r_cur) == h_eff - 11'd1) && (EW'(c_cur) == w_eff - EW'(1));
            dend_d  = (EW'(xm) + EW'(1) < EW'(nd_eff)) ? DW'(EW'(xm) + EW'(1)) : nd_eff;
            d_d     = '0;
            wx_d    = '0;
            wy_d    = '0;
            ws_d    = SW'(base_ext);
            lcol_d  = xm;
            acc_d   = '0;
            found_d = 1'b0;
            bestd_d = '0;
            state_d = (nd_eff == '0) ? ST_DONE : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        rv_d  = 1'b1;
        rl_d  = (wx_q == {hw_q, 1'b0}) && (wy_q == {hw_q, 1'b0});
        rdd_d = d_q;
        if (wx_q == {hw_q, 1'b0}) begin
          wx_d   = '0;
          lcol_d = col0_q;
          if (wy_q == {hw_q, 1'b0}) begin
            wy_d = '0;
            ws_d = base_q;
            d_d  = d_q + DW'(1);
            if (d_q + DW'(1) == dend_q) begin
              state_d = ST_DRAIN;
            end
          end else begin
            wy_d = wy_q + 4'd1;
            ws_d = (ws_q == SW'(MAX_BLOCK - 1)) ? '0 : ws_q + SW'(1);
          end
        end else begin
          wx_d   = wx_q + 4'd1;
          lcol_d = lcol_q + CIW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.best_disparity = 6'(bestd_q);
          out_d.pixel_column   = 10'(x_q);
          out_d.pixel_row      = y_q;
          out_d.frame_last     = last_q;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      slot_q      <= slot_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    hw_q    <= hw_d;
    base_q  <= base_d;
    dend_q  <= dend_d;
    col0_q  <= col0_d;
    last_q  <= last_d;
    d_q     <= d_d;
    wx_q    <= wx_d;
    wy_q    <= wy_d;
    ws_q    <= ws_d;
    lcol_q  <= lcol_d;
    rl_q    <= rl_d;
    rdd_q   <= rdd_d;
    acc_q   <= acc_d;
    best_q  <= best_d;
    bestd_q <= bestd_d;
    found_q <= found_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/sbm_checker.sv
// Port-level checks of the stereo SAD block matcher.
// Uses sbm_pkg; bound to stereo_sad_block_matcher.
module sbm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input sbm_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a search");

  a_disp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (10'(out_data_o.best_disparity) <= out_data_o.pixel_column))
    else $error("winning disparity reaches past the image border");

  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_stall_o |=> !out_valid_o)
    else $error("result repeated after transfer");

endmodule

bind stereo_sad_block_matcher sbm_checker u_sbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
